/* rtl/sdtq_pkg.sv */
package sdtq_pkg;

  // Field widths of the time stamp, the handles and the pending count.
  localparam int SEC_BITS = 40;
  localparam int NSEC_BITS = 30;
  localparam int IN_HANDLE_BITS = 16;
  localparam int OUT_HANDLE_BITS = 16;
  localparam int PENDING_BITS = 5;

  // Default sizing.
  localparam int DEPTH_DEFAULT = 16;
  localparam int HANDLE_BITS_DEFAULT = 16;

  // Input commands.
  localparam logic CMD_SCHEDULE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_SCHEDULED = 2'd0;
  localparam logic [1:0] KIND_FULL = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

endpackage

/* rtl/sorted_deadline_timer_queue.sv */
// Sorted deadline timer queue. The block holds up to DEPTH timers, each an
// absolute deadline (seconds, nanoseconds) with a handle, in ascending
// deadline order in a single RAM used as a ring (head pointer plus count).
// A schedule word inserts its deadline behind every entry of equal or earlier
// deadline, so equal deadlines leave in arrival order; a full store answers
// with a rejected result. A tick word carries the current time and pops,
// front first, every entry whose deadline is strictly earlier, one expired
// result per entry with last set on the final one, or a single none-expired
// result. Deadlines compare as raw (seconds, nanoseconds) pairs. One word is
// worked at a time through one RAM read port, one RAM write port and two
// 70-bit comparators under a small sequencer; in_stall is high while it works.
// A rejected schedule passes through a reject state that emits its result.
// An accepted schedule walks from the tail toward the head, reading and
// comparing each entry and moving every later one up a slot, writes the new
// entry into the freed slot and then emits its result. A tick walks from the
// head, reading, comparing and popping each expired entry, until an entry
// that has not expired or an empty store ends the walk, then emits the final
// result. Every step that emits a result waits while out_stall holds the
// result register. The store needs no clearing pass after reset: only the
// first count slots behind the head are ever read.
module sorted_deadline_timer_queue import sdtq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int HANDLE_BITS = HANDLE_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  logic [SEC_BITS-1:0]        time_sec,
  input  logic [NSEC_BITS-1:0]       time_nsec,
  input  logic [IN_HANDLE_BITS-1:0]  handle,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 kind,
  output logic [OUT_HANDLE_BITS-1:0] fired_handle,
  output logic                       last,
  output logic [PENDING_BITS-1:0]    pending
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = SEC_BITS + NSEC_BITS;
  localparam int W = KW + HANDLE_BITS;

  // Sequencer states.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_REJECT   = 3'd1;
  localparam logic [2:0] S_INS_RD   = 3'd2;
  localparam logic [2:0] S_INS_CMP  = 3'd3;
  localparam logic [2:0] S_INS_FIN  = 3'd4;
  localparam logic [2:0] S_TICK_RD  = 3'd5;
  localparam logic [2:0] S_TICK_CMP = 3'd6;
  localparam logic [2:0] S_TICK_FIN = 3'd7;

  logic [2:0]             state, state_next;
  logic [AW-1:0]          head, head_next;
  logic [CW-1:0]          count, count_next;
  logic [CW-1:0]          pos, pos_next;
  logic                   have_held, have_held_next;
  logic [HANDLE_BITS-1:0] held_handle, held_handle_next;
  logic [CW-1:0]          held_pend, held_pend_next;

  // The word being worked on.
  logic [SEC_BITS-1:0]    sec_r;
  logic [NSEC_BITS-1:0]   nsec_r;
  logic [HANDLE_BITS-1:0] handle_r;

  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [W-1:0]           rd_data, wr_data;

  logic                   emit;
  logic [1:0]             emit_kind;
  logic [HANDLE_BITS-1:0] emit_handle;
  logic                   emit_last;
  logic [CW-1:0]          emit_pend;

  logic                   out_free;
  logic [KW-1:0]          new_key, ent_key;
  logic                   new_lt_ent, ent_lt_now;
  logic [CW-1:0]          pos_m1;
  logic [AW-1:0]          head_inc;

  // Logical slot j of the ring to a RAM address.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] j);
    logic [AW:0] sum;
    sum = (AW+1)'(base) + (AW+1)'(j);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  sdtq_ram #(
    .WIDTH     (W),
    .DEPTH     (DEPTH),
    .ADDR_BITS (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // The two comparators: the word's time against the entry just read, each way.
  assign new_key = {sec_r, nsec_r};
  assign ent_key = rd_data[W-1:HANDLE_BITS];
  assign new_lt_ent = (new_key < ent_key);
  assign ent_lt_now = (ent_key < new_key);

  assign pos_m1 = pos - CW'(1);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);

  always_comb begin
    state_next = state;
    head_next = head;
    count_next = count;
    pos_next = pos;
    have_held_next = have_held;
    held_handle_next = held_handle;
    held_pend_next = held_pend;

    emit = 1'b0;
    emit_kind = KIND_SCHEDULED;
    emit_handle = '0;
    emit_last = 1'b1;
    emit_pend = count;

    rd_en = 1'b0;
    rd_addr = head;
    wr_en = 1'b0;
    wr_addr = phys(head, pos);
    wr_data = {sec_r, nsec_r, handle_r};

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          pos_next = count;
          have_held_next = 1'b0;
          if (command == CMD_TICK) begin
            state_next = S_TICK_RD;
          end else if (count == CW'(DEPTH)) begin
            state_next = S_REJECT;
          end else begin
            state_next = S_INS_RD;
          end
        end
      end

      S_REJECT: begin
        if (out_free) begin
          emit = 1'b1;
          emit_kind = KIND_FULL;
          state_next = S_IDLE;
        end
      end

      // Walk from the tail toward the head, moving later entries up a slot.
      S_INS_RD: begin
        if (pos == '0) begin
          wr_en = 1'b1;
          state_next = S_INS_FIN;
        end else begin
          rd_en = 1'b1;
          rd_addr = phys(head, pos_m1);
          state_next = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        wr_en = 1'b1;
        if (new_lt_ent) begin
          wr_data = rd_data;
          pos_next = pos_m1;
          state_next = S_INS_RD;
        end else begin
          state_next = S_INS_FIN;
        end
      end

      S_INS_FIN: begin
        if (out_free) begin
          emit = 1'b1;
          emit_kind = KIND_SCHEDULED;
          emit_pend = count + CW'(1);
          count_next = count + CW'(1);
          state_next = S_IDLE;
        end
      end

      S_TICK_RD: begin
        if (count == '0) begin
          state_next = S_TICK_FIN;
        end else begin
          rd_en = 1'b1;
          rd_addr = head;
          state_next = S_TICK_CMP;
        end
      end

      // An expired entry is held back one step so that the next compare can
      // tell whether it is the final result of this tick.
      S_TICK_CMP: begin
        if (ent_lt_now) begin
          if (!have_held || out_free) begin
            emit = have_held;
            emit_kind = KIND_EXPIRED;
            emit_handle = held_handle;
            emit_last = 1'b0;
            emit_pend = held_pend;
            held_handle_next = rd_data[HANDLE_BITS-1:0];
            held_pend_next = count - CW'(1);
            have_held_next = 1'b1;
            count_next = count - CW'(1);
            head_next = head_inc;
            state_next = S_TICK_RD;
          end
        end else begin
          state_next = S_TICK_FIN;
        end
      end

      S_TICK_FIN: begin
        if (out_free) begin
          emit = 1'b1;
          emit_last = 1'b1;
          if (have_held) begin
            emit_kind = KIND_EXPIRED;
            emit_handle = held_handle;
            emit_pend = held_pend;
          end else begin
            emit_kind = KIND_NONE;
            emit_pend = count;
          end
          have_held_next = 1'b0;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      count <= '0;
      pos <= '0;
      have_held <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head <= head_next;
      count <= count_next;
      pos <= pos_next;
      have_held <= have_held_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    held_handle <= held_handle_next;
    held_pend <= held_pend_next;
    if (state == S_IDLE && in_valid) begin
      sec_r <= time_sec;
      nsec_r <= time_nsec;
      handle_r <= HANDLE_BITS'(handle);
    end
    if (emit) begin
      kind <= emit_kind;
      fired_handle <= OUT_HANDLE_BITS'(emit_handle);
      last <= emit_last;
      pending <= PENDING_BITS'(emit_pend);
    end
  end

  // The store never claims more timers than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("timer count exceeds depth");

  // Timers enter and leave one at a time.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count) || count == $past(count) + CW'(1) ||
              count == $past(count) - CW'(1)))
    else $error("timer count jumped by more than one");

  // No expired entry is left behind once the block takes a new word.
  a_no_held_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !have_held)
    else $error("held expired entry while ready");

endmodule

/* rtl/sdtq_ram.sv */
module sdtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data is registered and holds until the next read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
